### src/lrg_pkg.sv
package lrg_pkg;

	localparam int NumFeaturesDef = 4;
	localparam int CountBitsDef   = 24;
	localparam int MaxFeatures    = 4;
	localparam int AccW           = 48;
	localparam int SqW            = 64;
	localparam int NumRegs        = 7;

	localparam logic [2:0] RegWeight0 = 3'd0;
	localparam logic [2:0] RegWeight1 = 3'd1;
	localparam logic [2:0] RegWeight2 = 3'd2;
	localparam logic [2:0] RegWeight3 = 3'd3;
	localparam logic [2:0] RegBias    = 3'd4;
	localparam logic [2:0] RegRidgeEn = 3'd5;
	localparam logic [2:0] RegLambda  = 3'd6;
	localparam logic [2:0] BiasIndex  = 3'd4;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_ACC,
		ST_DIV,
		ST_EMIT
	} state_t;

	// saturating signed 48-bit add
	function automatic logic signed [AccW-1:0] sat_add48(
		input logic signed [AccW-1:0] a,
		input logic signed [AccW-1:0] b
	);
		logic signed [AccW:0] s;
		s = {a[AccW-1], a} + {b[AccW-1], b};
		if (s > $signed({1'b0, AccMax})) return AccMax;
		if (s < $signed({1'b1, AccMin})) return AccMin;
		return s[AccW-1:0];
	endfunction

endpackage

### src/lrg_lane.sv
// One feature lane: product w*x, then x*e accumulated into a saturating sum.
module lrg_lane import lrg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   enable,
	input  logic                   load,
	input  logic                   acc,
	input  logic                   clr,
	input  logic signed [15:0]     feature,
	input  logic signed [15:0]     weight,
	input  logic signed [23:0]     err,
	output logic signed [31:0]     prod,
	output logic signed [AccW-1:0] sum
);
	logic signed [15:0] x_q;
	logic signed [31:0] prod_q;
	logic signed [39:0] xe_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= feature;
			prod_q <= enable ? feature * weight : 32'sd0;
		end
	end

	assign xe_s1 = x_q * err;
	assign prod  = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum <= '0;
		end else if (clr) begin
			sum <= '0;
		end else if (acc && enable) begin
			sum <= sat_add48(sum, {{(AccW-40){xe_s1[39]}}, xe_s1});
		end
	end
endmodule

### src/lrg_divider.sv
// Restoring divider for unsigned dividends, one quotient bit per cycle.
module lrg_divider import lrg_pkg::*; #(
	parameter int DenW = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SqW+1:0]  dividend,
	input  logic [DenW-1:0] divisor,
	output logic            busy,
	output logic [SqW+1:0]  quotient
);
	localparam int NumW = SqW + 2;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [DenW:0]   rem_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW+1:0] trial;

	assign trial    = {rem_q, num_q[NumW-1]} - {2'b00, divisor};
	assign busy     = (cnt_q != '0);
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[DenW+1]) begin
				rem_q <= trial[DenW:0];
				num_q <= {num_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DenW-1:0], num_q[NumW-1]};
				num_q <= {num_q[NumW-2:0], 1'b0};
			end
		end
	end
endmodule

### src/linear_regression_gradient.sv
// Ridge linear regression gradient unit. Samples are taken one at a time, each
// only once the last is accumulated: four lane multipliers form the prediction,
// an adder tree gives the error, and the lanes accumulate x*e. A sample marked
// last starts the batch close-out: loss and each gradient need one serial divide
// by the sample count, and no further sample is taken until the batch results
// have left, which output back-pressure can delay. Results leave one per transfer
// through an output register, weight gradients first, then the bias gradient.
module linear_regression_gradient import lrg_pkg::*; #(
	parameter int LANE_COUNT = NumFeaturesDef,
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] feature_zero,
	input  logic signed [15:0] feature_one,
	input  logic signed [15:0] feature_two,
	input  logic signed [15:0] feature_three,
	input  logic signed [15:0] target_value,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         param_index,
	output logic signed [31:0] gradient_value,
	output logic [31:0]        loss_value,
	output logic               count_saturated,
	output logic               last_result
);
	logic signed [15:0] w_q [MaxFeatures];
	logic signed [15:0] bias_q;
	logic               ridge_q;
	logic [15:0]        lambda_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxFeatures; i++) w_q[i] <= '0;
			bias_q   <= '0;
			ridge_q  <= 1'b0;
			lambda_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegWeight0: w_q[0]   <= cfg_data;
				RegWeight1: w_q[1]   <= cfg_data;
				RegWeight2: w_q[2]   <= cfg_data;
				RegWeight3: w_q[3]   <= cfg_data;
				RegBias:    bias_q   <= cfg_data;
				RegRidgeEn: ridge_q  <= cfg_data[0];
				RegLambda:  lambda_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic   last_q;
	logic signed [15:0] tgt_q;
	logic signed [15:0] feat [MaxFeatures];
	logic signed [31:0] prod [MaxFeatures];
	logic signed [AccW-1:0] lsum [MaxFeatures];
	logic [MaxFeatures-1:0] lane_en;

	assign feat = '{feature_zero, feature_one, feature_two, feature_three};

	logic in_xfer, load, acc, clr;
	assign in_xfer = in_valid && in_ready;
	assign load    = in_xfer;
	assign acc     = (state_q == ST_ACC);

	logic signed [23:0] e11;
	logic signed [35:0] e22;
	logic signed [35:0] e_mag;

	always_comb begin
		e22 = 36'(bias_q) * 36'sd2048 - 36'(tgt_q) * 36'sd2048;
		for (int i = 0; i < MaxFeatures; i++) e22 = e22 + 36'(prod[i]);
	end
	// truncate toward zero: Q.22 to Q.11
	assign e_mag = e22[35] ? -e22 : e22;
	logic signed [35:0] e_sh;
	assign e_sh = e22[35] ? -(e_mag >>> 11) : (e_mag >>> 11);
	logic signed [23:0] err_q;
	assign e11 = e_sh[23:0];

	always_ff @(posedge clk) begin
		if (load) begin
			tgt_q  <= target_value;
			last_q <= last_sample;
		end
		if (state_q == ST_PROD) err_q <= e11;
	end

	for (genvar g = 0; g < MaxFeatures; g++) begin : g_lane
		assign lane_en[g] = (g < LANE_COUNT);
		lrg_lane u_lane (
			.clk(clk), .arst_n(arst_n), .enable(lane_en[g]), .load(load), .acc(acc),
			.clr(clr), .feature(feat[g]), .weight(w_q[g]), .err(err_q),
			.prod(prod[g]), .sum(lsum[g])
		);
	end

	logic signed [AccW-1:0] esum_q;
	logic [SqW-1:0]         sqsum_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic signed [47:0]     sq_e;
	logic [SqW:0]           sq_add;
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	assign sq_e   = err_q * err_q;
	assign sq_add = {1'b0, sqsum_q} + {17'd0, sq_e};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q  <= '0;
			sqsum_q <= '0;
			cnt_q   <= '0;
		end else if (clr) begin
			esum_q  <= '0;
			sqsum_q <= '0;
			cnt_q   <= '0;
		end else if (acc) begin
			esum_q  <= sat_add48(esum_q, {{(AccW-24){err_q[23]}}, err_q});
			sqsum_q <= sq_add[SqW] ? '1 : sq_add[SqW-1:0];
			if (cnt_q != CntMax) cnt_q <= cnt_q + 1'b1;
		end
	end

	// close-out sequencing: item 0 is loss, then one per gradient
	logic [2:0]  item_q;
	logic        div_start, div_busy;
	logic [SqW+1:0] dividend, quotient;
	logic        neg_q;

	logic signed [AccW-1:0] cur_sum;
	always_comb begin
		cur_sum = esum_q;
		case (item_q)
			3'd1: cur_sum = lsum[0];
			3'd2: cur_sum = lsum[1];
			3'd3: cur_sum = lsum[2];
			3'd4: cur_sum = lsum[3];
			default: cur_sum = esum_q;
		endcase
	end
	logic [AccW-1:0] cur_mag;
	assign cur_mag = cur_sum[AccW-1] ? AccW'(-cur_sum) : AccW'(cur_sum);

	always_comb begin
		if (item_q == 3'd0)
			dividend = {sqsum_q, 2'b00};
		else if (item_q == 3'd5)
			dividend = (SqW+2)'({cur_mag, 13'b0});
		else
			dividend = (SqW+2)'({cur_mag, 2'b0});
	end

	lrg_divider #(.DenW(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dividend),
		.divisor(cnt_q), .busy(div_busy), .quotient(quotient)
	);

	logic [2:0] nf;
	assign nf = 3'(LANE_COUNT);

	// ridge terms
	logic signed [31:0] wsq [MaxFeatures];
	logic [33:0] sqw;
	logic [50:0] ridge_loss;
	always_comb begin
		sqw = '0;
		for (int i = 0; i < MaxFeatures; i++) begin
			wsq[i] = w_q[i] * w_q[i];
			if (i < LANE_COUNT) sqw = sqw + 34'(wsq[i]);
		end
	end
	assign ridge_loss = 51'((sqw * 51'(lambda_q)) >> 14);

	logic signed [15:0] cur_w;
	assign cur_w = (item_q >= 3'd1 && item_q <= 3'd4) ? w_q[item_q[1:0] - 2'd1] : '0;
	logic signed [32:0] lw;
	logic signed [32:0] lw_mag, ridge_g;
	assign lw      = $signed({1'b0, lambda_q}) * cur_w;
	assign lw_mag  = lw[32] ? -lw : lw;
	assign ridge_g = lw[32] ? -(lw_mag >>> 3) : (lw_mag >>> 3);

	logic signed [SqW+3:0] grad;
	logic [SqW+1:0]        loss_full;
	logic [31:0]           loss_q;
	logic signed [31:0]    grad_q;
	logic [2:0]            pidx_q;
	logic                  ovalid_q, olast_q;

	assign grad = (neg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient}))
		+ ((ridge_q && item_q != 3'd5) ? (SqW+4)'(ridge_g) : (SqW+4)'(0));
	assign loss_full = (quotient[SqW+1:32] != '0) ? (SqW+2)'(32'hFFFF_FFFF) : quotient;

	logic div_wait_q;
	logic fin;
	assign fin = div_wait_q && !div_busy;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		clr       = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer) state_d = ST_PROD;
			end
			ST_PROD: state_d = ST_ACC;
			ST_ACC:  state_d = last_q ? ST_DIV : ST_IDLE;
			ST_DIV: begin
				if (!div_wait_q && !(ovalid_q && !out_ready)) div_start = 1'b1;
				if (fin && item_q == 3'd5) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ovalid_q || out_ready) begin
					clr     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	logic [2:0] next_item;
	assign next_item = (item_q == 3'd0) ? ((nf == 3'd0) ? 3'd5 : 3'd1)
		: ((item_q >= nf) ? 3'd5 : item_q + 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			item_q     <= '0;
			div_wait_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (state_q == ST_ACC) item_q <= '0;
			if (div_start) div_wait_q <= 1'b1;
			else if (fin) begin
				div_wait_q <= 1'b0;
				if (item_q == 3'd0) begin
					item_q <= next_item;
				end else begin
					ovalid_q <= 1'b1;
					if (item_q != 3'd5) item_q <= next_item;
				end
			end
		end
	end

	logic [32:0] loss_sum;
	assign loss_sum = {1'b0, loss_full[31:0]} + (ridge_q ? 33'(ridge_loss) : 33'd0);

	always_ff @(posedge clk) begin
		if (div_start) neg_q <= (item_q != 3'd0) && cur_sum[AccW-1];
		if (fin && item_q == 3'd0)
			loss_q <= (loss_sum[32] || (ridge_q && ridge_loss[50:32] != '0))
				? 32'hFFFF_FFFF : loss_sum[31:0];
		if (fin && item_q != 3'd0) begin
			pidx_q  <= (item_q == 3'd5) ? BiasIndex : item_q - 3'd1;
			olast_q <= (item_q == 3'd5);
			if (grad > $signed((SqW+4)'(32'sh7FFF_FFFF)))
				grad_q <= 32'sh7FFF_FFFF;
			else if (grad < -$signed((SqW+4)'(33'sh0_8000_0000)))
				grad_q <= 32'sh8000_0000;
			else
				grad_q <= grad[31:0];
		end
	end

	assign out_valid       = ovalid_q;
	assign param_index     = pidx_q;
	assign gradient_value  = grad_q;
	assign loss_value      = loss_q;
	assign count_saturated = (cnt_q == CntMax);
	assign last_result     = olast_q;

	ap_no_in_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	ap_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	ap_clear_after_bias: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (cnt_q == '0)) else $error("sums not cleared");
endmodule

### tb/sv/tb_linear_regression_gradient.sv
`timescale 1ns / 1ps

module tb_linear_regression_gradient;
	import lrg_pkg::*;

	localparam logic [2:0] RegUnused = 3'd7;
	localparam int WatchdogLimit = 6000;
	localparam longint AccHi = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint AccLo = -AccHi - 1;
	localparam longint unsigned CountMax = (64'd1 << CountBitsDef) - 1;

	typedef struct packed {
		logic [3:0][15:0] feat;
		logic [15:0]      target;
		logic             last;
	} sample_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [31:0] grad;
		logic [31:0] loss;
		logic        csat;
		logic        last;
	} grad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] feature_zero = '0, feature_one = '0, feature_two = '0;
	logic signed [15:0] feature_three = '0, target_value = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] param_index;
	logic signed [31:0] gradient_value;
	logic [31:0] loss_value;
	logic count_saturated, last_result;

	linear_regression_gradient DUT (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	sample_t sample_queue[$];
	grad_t   grad_expect[$];
	sample_t cur_sample;
	int      pushed_total = 0, accepted_total = 0, batch_total = 0, result_total = 0;
	int      error_count = 0;
	bit      no_idle = 1'b0;
	bit      long_hold_go = 1'b0;

	// shadow of the register file and running sums
	logic [15:0] reg_shadow[NumRegs];
	longint wgrad_acc[4];
	longint err_acc;
	longint unsigned sqerr_acc;
	longint unsigned sample_cnt;

	function automatic longint sat48(longint v);
		if (v > AccHi) return AccHi;
		if (v < AccLo) return AccLo;
		return v;
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic int gap_len();
		if (no_idle || $urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// fold one sample into the sums; close out the batch on the last one
	task automatic accumulate_sample(input sample_t s);
		longint w[4], x[4], pred, e11, grad, n;
		longint unsigned sq, q, r, loss, sqw;
		bit ridge;
		grad_t g;
		ridge = reg_shadow[RegRidgeEn][0];
		pred = longint'($signed(reg_shadow[RegBias])) * 2048;
		for (int i = 0; i < 4; i++) begin
			w[i] = longint'($signed(reg_shadow[i]));
			x[i] = longint'($signed(s.feat[i]));
			pred += x[i] * w[i];
		end
		e11 = (pred - longint'($signed(s.target)) * 2048) / 2048;
		for (int i = 0; i < 4; i++) wgrad_acc[i] = sat48(wgrad_acc[i] + x[i] * e11);
		err_acc = sat48(err_acc + e11);
		sq = longint'(e11 * e11);
		sqerr_acc = (sqerr_acc > ~64'd0 - sq) ? ~64'd0 : sqerr_acc + sq;
		if (sample_cnt < CountMax) sample_cnt++;
		if (!s.last) return;
		n = longint'(sample_cnt);
		q = sqerr_acc / sample_cnt;
		r = sqerr_acc % sample_cnt;
		loss = (q >= (64'd1 << 30)) ? 64'hFFFF_FFFF : 4 * q + (4 * r) / sample_cnt;
		if (ridge) begin
			sqw = 0;
			for (int i = 0; i < 4; i++) sqw += longint'(w[i] * w[i]);
			loss += (sqw * reg_shadow[RegLambda]) >> 14;
		end
		if (loss > 64'hFFFF_FFFF) loss = 64'hFFFF_FFFF;
		g.loss = loss[31:0];
		g.csat = (sample_cnt == CountMax);
		for (int i = 0; i < 4; i++) begin
			grad = (wgrad_acc[i] * 4) / n;
			if (ridge) grad += (longint'(reg_shadow[RegLambda]) * w[i]) / 8;
			g.idx = 3'(i);
			g.grad = sat32(grad);
			g.last = 1'b0;
			grad_expect.push_back(g);
		end
		g.idx = BiasIndex;
		g.grad = sat32((err_acc * 8192) / n);
		g.last = 1'b1;
		grad_expect.push_back(g);
		batch_total++;
		for (int i = 0; i < 4; i++) wgrad_acc[i] = 0;
		err_acc = 0;
		sqerr_acc = 0;
		sample_cnt = 0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", result_total, what, got, want);
		error_count++;
	endtask

	// sample driver
	int send_gap = 0;
	always @(posedge clk) begin
		bit busy;
		sample_t nxt;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				accumulate_sample(cur_sample);
				accepted_total++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					nxt = sample_queue.pop_front();
					cur_sample <= nxt;
					feature_zero <= nxt.feat[0];
					feature_one <= nxt.feat[1];
					feature_two <= nxt.feat[2];
					feature_three <= nxt.feat[3];
					target_value <= nxt.target;
					last_sample <= nxt.last;
					in_valid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	int  recv_gap = 0;
	bit  long_hold_started = 1'b0;
	always @(posedge clk) begin
		grad_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (grad_expect.size() == 0) begin
					report_mismatch("unexpected", {29'd0, param_index}, 32'd0);
				end else begin
					want = grad_expect.pop_front();
					if (param_index !== want.idx)
						report_mismatch("param_index", 32'(param_index), 32'(want.idx));
					if (gradient_value !== want.grad)
						report_mismatch("gradient_value", gradient_value, want.grad);
					if (loss_value !== want.loss)
						report_mismatch("loss_value", loss_value, want.loss);
					if (count_saturated !== want.csat)
						report_mismatch("count_saturated", 32'(count_saturated), 32'(want.csat));
					if (last_result !== want.last)
						report_mismatch("last_result", 32'(last_result), 32'(want.last));
				end
				result_total++;
			end
			if (long_hold_go && !long_hold_started) begin
				long_hold_started <= 1'b1;
				recv_gap <= 900;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) < 3) begin
				recv_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
						: $urandom_range(10, 60);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("linear_regression_gradient test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < NumRegs) reg_shadow[idx] = (idx == RegRidgeEn) ? {15'd0, data[0]} : data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(input logic [15:0] f0, f1, f2, f3, tgt, input logic lst);
		sample_t s;
		s.feat = {f3, f2, f1, f0};
		s.target = tgt;
		s.last = lst;
		sample_queue.push_back(s);
		pushed_total++;
	endtask

	// wait for every sample and every result, then let the block settle
	task automatic drain();
		while (accepted_total != pushed_total || grad_expect.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_word(input bit narrow);
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return narrow ? 16'($urandom_range(0, 4095) - 2048) : 16'($urandom);
		endcase
	endfunction

	task automatic random_batches(input int count, input bit narrow);
		int left, len;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
			if (len > left) len = left;
			for (int k = 0; k < len; k++)
				push_sample(rand_word(narrow), rand_word(narrow), rand_word(narrow),
					rand_word(narrow), rand_word(narrow), k == len - 1);
			left -= len;
		end
	endtask

	task automatic random_config(input bit narrow);
		for (int i = 0; i < 5; i++) write_reg(3'(i), rand_word(narrow));
		write_reg(RegRidgeEn, 16'($urandom));
		write_reg(RegLambda, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
	endtask

	initial begin
		for (int i = 0; i < NumRegs; i++) reg_shadow[i] = '0;
		for (int i = 0; i < 4; i++) wgrad_acc[i] = 0;
		err_acc = 0;
		sqerr_acc = 0;
		sample_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: error equals minus the target
		push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
		push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
		push_sample(16'h0001, 16'hFFFF, 16'h1234, 16'hEDCB, 16'h0800, 1'b1);
		drain();

		// extreme weights with full ridge; high register bits and a bad index dropped
		write_reg(RegWeight0, 16'h7FFF);
		write_reg(RegWeight1, 16'h8000);
		write_reg(RegWeight2, 16'h7FFF);
		write_reg(RegWeight3, 16'h8000);
		write_reg(RegBias, 16'h7FFF);
		write_reg(RegRidgeEn, 16'hFFFF);
		write_reg(RegLambda, 16'hFFFF);
		write_reg(RegUnused, 16'h1234);
		push_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b1);
		push_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
		for (int k = 0; k < 6; k++)
			push_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, k == 5);
		drain();

		write_reg(RegRidgeEn, 16'hFFFE);
		write_reg(RegBias, 16'h8000);
		write_reg(RegLambda, 16'h0001);
		push_sample(16'h0800, 16'hF800, 16'h0000, 16'h0400, 16'h0000, 1'b1);
		push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		drain();

		// random phases; one runs flat out, one starts behind a long receiver hold
		for (int ph = 0; ph < 6; ph++) begin
			random_config(ph[0]);
			no_idle = (ph == 2);
			if (ph == 3) long_hold_go <= 1'b1;
			random_batches(40, ph[0]);
			drain();
		end
		no_idle = 1'b0;
		write_reg(RegRidgeEn, 16'h0000);
		write_reg(RegLambda, 16'h0000);
		random_batches(10, 1'b1);
		drain();

		$display("covered %0d samples in %0d batches, %0d gradient results checked",
			accepted_total, batch_total, result_total);
		$display("register settings included reset, extreme weights and full ridge strength");
		if (error_count == 0) begin
			$display("linear_regression_gradient test passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("linear_regression_gradient test failed");
		end
		$finish;
	end

endmodule

### filelist.f
src/lrg_pkg.sv
src/lrg_lane.sv
src/lrg_divider.sv
src/linear_regression_gradient.sv
tb/sv/tb_linear_regression_gradient.sv
